/* rtl/bbt_pkg.sv */
// ----------------------------------------------------------------------------
// bbt_pkg
// Shared types, codes and direction helpers of the binary boundary tracer.
// ----------------------------------------------------------------------------
package bbt_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   // Clamp arithmetic width: holds the largest supported image dimension
   localparam int DIM_W = 13;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0]  CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0]  CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [CSR_DATA_W-1:0] DIM_RESET        = 10'd512;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam int           NUM_DIRS  = 8;
   localparam int           PROBE_W   = 4;
   localparam logic [2:0]   DIR_START = 3'd5;

   typedef struct packed {
      logic       opcode;
      logic [8:0] pixel_x;
      logic [8:0] pixel_y;
      logic       pixel_on;
   } req_type;

   typedef struct packed {
      logic [8:0] point_x;
      logic [8:0] point_y;
      logic       is_last;
      logic       start_found;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SEARCH
   } state_type;

   typedef struct packed {
      logic write_pixel;
      logic scan_start;
      logic search_start;
      logic scan_step;
      logic search_step;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic exhausted;
      logic last;
   } status_type;

   // First neighbor probed after arriving with direction dir
   function automatic logic [2:0] dir_first(input logic [2:0] dir);
      return dir[0] ? dir + 3'd6 : dir + 3'd7;
   endfunction

   function automatic logic moves_east(input logic [2:0] d);
      return (d == 3'd0) || (d == 3'd1) || (d == 3'd7);
   endfunction

   function automatic logic moves_west(input logic [2:0] d);
      return (d == 3'd3) || (d == 3'd4) || (d == 3'd5);
   endfunction

   function automatic logic moves_north(input logic [2:0] d);
      return (d == 3'd1) || (d == 3'd2) || (d == 3'd3);
   endfunction

   function automatic logic moves_south(input logic [2:0] d);
      return (d == 3'd5) || (d == 3'd6) || (d == 3'd7);
   endfunction

endpackage

/* rtl/bbt_ctrl.sv */
// ----------------------------------------------------------------------------
// bbt_ctrl
// Sequencer: start-column scan, neighbor search and trace-active tracking.
// ----------------------------------------------------------------------------
module bbt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_opcode,
   input  logic                   csr_we,
   input  bbt_pkg::status_type    status,
   output logic                   busy,
   output bbt_pkg::cmd_type       cmd
);
   import bbt_pkg::*;

   state_type state_ff, state_in;
   logic      trace_active_ff, trace_active_in;
   logic      accept;
   logic      done;

   assign accept = start && (state_ff == ST_IDLE);
   assign done   = status.hit || status.exhausted;
   assign busy   = (state_ff != ST_IDLE);

   // Next state
   always_comb begin
      state_in        = state_ff;
      trace_active_in = trace_active_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_STEP) begin
               state_in = trace_active_ff ? ST_SEARCH : ST_SCAN;
            end else if (accept) begin
               trace_active_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (done) begin
               state_in        = ST_IDLE;
               trace_active_in = 1'b1;
            end
         end
         ST_SEARCH: begin
            if (done) begin
               state_in        = ST_IDLE;
               trace_active_in = !status.last;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we) begin
         trace_active_in = 1'b0;
      end
   end

   // Outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.write_pixel  = accept && (req_opcode == OP_WRITE);
            cmd.scan_start   = accept && (req_opcode == OP_STEP) && !trace_active_ff;
            cmd.search_start = accept && (req_opcode == OP_STEP) && trace_active_ff;
         end
         ST_SCAN:   cmd.scan_step   = 1'b1;
         ST_SEARCH: cmd.search_step = 1'b1;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         trace_active_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         trace_active_ff <= trace_active_in;
      end
   end

endmodule

/* rtl/bbt_datapath.sv */
// ----------------------------------------------------------------------------
// bbt_datapath
// Pixel memory, dimension registers, probe pipeline and result register.
// ----------------------------------------------------------------------------
module bbt_datapath #(
   parameter int MAX_WIDTH  = bbt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bbt_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bbt_pkg::req_type                  req_data,
   input  logic                              csr_we,
   input  logic [bbt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  bbt_pkg::cmd_type                  cmd,
   output bbt_pkg::status_type               status,
   output logic                              rsp_strobe,
   output bbt_pkg::rsp_type                  rsp_data
);
   import bbt_pkg::*;

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   logic pixel_mem [DEPTH];

   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic [XW-1:0]         cur_x_ff, cur_x_in;
   logic [YW-1:0]         cur_y_ff, cur_y_in;
   logic [2:0]            dir_ff, dir_in;
   logic                  start_seen_ff, start_seen_in;
   logic [PROBE_W-1:0]    probe_ff;
   logic [YW:0]           scan_y_ff;
   logic                  pend_ff, pend_in;
   logic [XW-1:0]         pend_x_ff;
   logic [YW-1:0]         pend_y_ff;
   logic [2:0]            pend_dir_ff;
   logic                  rd_ff;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [DIM_W-1:0] w_raw, h_raw, w_clamp, h_clamp;
   logic [XW-1:0]    w_last;
   logic [YW-1:0]    h_last;
   logic [2:0]       probe_dir;
   logic [XW-1:0]    cand_x;
   logic [YW-1:0]    cand_y;
   logic             cand_ok;
   logic             stepping;
   logic             more;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;
   logic             wr_ok;
   logic             finish;
   logic [XW+8:0]    wr_x_ext, out_x_ext;
   logic [YW+8:0]    wr_y_ext, out_y_ext;

   function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
      return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
   endfunction

   // Effective dimensions: zero acts as one, oversize acts as the maximum
   always_comb begin
      w_raw   = DIM_W'(width_ff);
      h_raw   = DIM_W'(height_ff);
      w_clamp = (w_raw == '0) ? DIM_W'(1) :
                (w_raw > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_raw;
      h_clamp = (h_raw == '0) ? DIM_W'(1) :
                (h_raw > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_raw;
   end
   assign w_last = XW'(w_clamp - DIM_W'(1));
   assign h_last = YW'(h_clamp - DIM_W'(1));

   // Neighbor candidate for the current probe
   always_comb begin
      probe_dir = dir_first(dir_ff) + probe_ff[2:0];
      cand_x    = cur_x_ff;
      cand_y    = cur_y_ff;
      if (moves_east(probe_dir))  cand_x = cur_x_ff + XW'(1);
      if (moves_west(probe_dir))  cand_x = cur_x_ff - XW'(1);
      if (moves_north(probe_dir)) cand_y = cur_y_ff - YW'(1);
      if (moves_south(probe_dir)) cand_y = cur_y_ff + YW'(1);
      cand_ok = !(moves_east(probe_dir)  && cur_x_ff >= w_last) &&
                !(moves_west(probe_dir)  && cur_x_ff == '0) &&
                !(moves_north(probe_dir) && cur_y_ff == '0) &&
                !(moves_south(probe_dir) && cur_y_ff >= h_last);
   end

   // One read issued per cycle while a step has reads left; its data and tag come back in the next cycle
   always_comb begin
      stepping = cmd.scan_step || cmd.search_step;
      more     = cmd.scan_step ? (scan_y_ff <= (YW+1)'(h_last))
                               : (probe_ff < PROBE_W'(NUM_DIRS));
      rd_en    = stepping && more;
      rd_addr  = cmd.scan_step ? addr_of(w_last, scan_y_ff[YW-1:0]) : addr_of(cand_x, cand_y);
      pend_in  = rd_en && (cmd.scan_step || cand_ok);

      status.hit       = pend_ff && rd_ff;
      status.exhausted = !more && !status.hit;
      status.last      = cmd.search_step &&
                         (status.hit ? (pend_x_ff == w_last) : (w_last == '0));
      finish           = stepping && (status.hit || status.exhausted);
   end

   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      dir_in        = dir_ff;
      start_seen_in = start_seen_ff;
      if (finish) begin
         cur_x_in = status.hit ? pend_x_ff : '0;
         cur_y_in = status.hit ? pend_y_ff : '0;
         if (cmd.scan_step) begin
            dir_in        = DIR_START;
            start_seen_in = status.hit;
         end else if (status.hit) begin
            dir_in = pend_dir_ff;
         end
      end
      out_x_ext               = (XW+9)'(cur_x_in);
      out_y_ext               = (YW+9)'(cur_y_in);
      rsp_data_in.point_x     = out_x_ext[8:0];
      rsp_data_in.point_y     = out_y_ext[8:0];
      rsp_data_in.is_last     = status.last;
      rsp_data_in.start_found = start_seen_in;
   end

   // Pixel write port
   always_comb begin
      wr_x_ext = (XW+9)'(req_data.pixel_x);
      wr_y_ext = (YW+9)'(req_data.pixel_y);
      wr_ok    = (32'(req_data.pixel_x) < MAX_WIDTH) && (32'(req_data.pixel_y) < MAX_HEIGHT);
      wr_addr  = addr_of(wr_x_ext[XW-1:0], wr_y_ext[YW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.write_pixel && wr_ok) begin
         pixel_mem[wr_addr] <= req_data.pixel_on;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= pixel_mem[rd_addr];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (rd_en) begin
         pend_x_ff   <= cmd.scan_step ? w_last : cand_x;
         pend_y_ff   <= cmd.scan_step ? scan_y_ff[YW-1:0] : cand_y;
         pend_dir_ff <= probe_dir;
      end
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= DIM_RESET;
         height_ff     <= DIM_RESET;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         dir_ff        <= DIR_START;
         start_seen_ff <= 1'b0;
         probe_ff      <= '0;
         scan_y_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default:          width_ff  <= width_ff;
            endcase
         end
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         dir_ff        <= dir_in;
         start_seen_ff <= start_seen_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= finish;
         if (cmd.search_start) begin
            probe_ff <= '0;
         end else if (rd_en && cmd.search_step) begin
            probe_ff <= probe_ff + PROBE_W'(1);
         end
         if (cmd.scan_start) begin
            scan_y_ff <= '0;
         end else if (rd_en && cmd.scan_step) begin
            scan_y_ff <= scan_y_ff + (YW+1)'(1);
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

/* rtl/binary_boundary_tracer.sv */
// ----------------------------------------------------------------------------
// binary_boundary_tracer
// Moore-neighbor boundary tracer over a bit-per-pixel image memory.
// ----------------------------------------------------------------------------
// Pixel write: no result, busy stays low.
// First step of a trace: walks the rightmost column, one memory read per cycle,
//   then strobes its result.
// Later steps: probe up to eight neighbors, one read per cycle, then strobe the
//   result. start is taken again in the strobe cycle.
// Reset: no trace active, both dimensions 512; the pixel memory is not cleared.
module binary_boundary_tracer #(
   parameter int MAX_WIDTH  = bbt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bbt_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bbt_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output bbt_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [bbt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bbt_pkg::*;

   cmd_type    cmd;
   status_type status;

   bbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_data.opcode),
      .csr_we     (csr_we),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   bbt_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // A result only closes a step that was in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a step in progress");

   // The block is free again in the cycle its result is shown
   a_rsp_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy while result strobes");

   // A step transfer always starts work; a pixel write never does
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy == $past(req_data.opcode == OP_STEP)))
      else $error("busy does not follow the accepted opcode");

endmodule
